// ===== hdl/pfcs_pkg.sv =====
package pfcs_pkg;

  localparam int MAX_FILES  = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int STAMP_BITS = 32;
  localparam int PROG_W     = 63;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [2:0] OP_BEGIN = 3'd0;
  localparam logic [2:0] OP_PROG  = 3'd1;
  localparam logic [2:0] OP_PRIO  = 3'd2;
  localparam logic [2:0] OP_OPEN  = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;

  localparam logic [5:0] MASK_STATIC = 6'h07;
  localparam logic [5:0] MASK_PROG   = 6'h08;
  localparam logic [5:0] MASK_PRIO   = 6'h10;
  localparam logic [5:0] MASK_MODE   = 6'h20;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]            op;
    logic [IDX_W-1:0]      idx;
    logic                  in_range;
    logic [PROG_W-1:0]     prog;
    logic [2:0]            prio;
    logic [7:0]            mode;
    logic [STAMP_BITS-1:0] since;
    logic [5:0]            req;
    logic [CNT_W-1:0]      n;
  } cmd_t;

endpackage

// ===== hdl/pfcs_front.sv =====
module pfcs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pfcs_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_op,
  input  logic [pfcs_pkg::IDX_W-1:0]   in_file_index,
  input  logic [pfcs_pkg::PROG_W-1:0]  in_progress_value,
  input  logic [2:0]                   in_priority_value,
  input  logic [7:0]                   in_mode_value,
  input  logic [31:0]                  in_since_frame,
  input  logic [5:0]                   in_requested_mask,
  output logic                         q_valid,
  output pfcs_pkg::cmd_t               q_cmd,
  input  logic                         q_pop
);
  import pfcs_pkg::*;

  logic [CNT_W-1:0]  file_count_r;
  logic [CNT_W-1:0]  n_eff;
  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_count_r <= CNT_W'(MAX_FILES);
    end else if (cfg_we) begin
      file_count_r <= cfg_wdata;
    end
  end

  assign n_eff    = (file_count_r > CNT_W'(MAX_FILES)) ? CNT_W'(MAX_FILES) : file_count_r;
  assign in_stall = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall && (in_op <= OP_QUERY);

  // command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].op       <= in_op;
      mem_r[wp_r].idx      <= in_file_index;
      mem_r[wp_r].in_range <= {1'b0, in_file_index} < n_eff;
      mem_r[wp_r].prog     <= in_progress_value;
      mem_r[wp_r].prio     <= in_priority_value;
      mem_r[wp_r].mode     <= in_mode_value;
      mem_r[wp_r].since    <= in_since_frame;
      mem_r[wp_r].req      <= in_requested_mask;
      mem_r[wp_r].n        <= n_eff;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rp_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH)) else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (QPTR_W+1)'(QDEPTH)) |-> in_stall) else $error("full without stall");
`endif

endmodule

// ===== hdl/pfcs_back.sv =====
module pfcs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  pfcs_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [31:0]                 out_frame_number,
  output logic [pfcs_pkg::IDX_W-1:0]  out_out_index,
  output logic [5:0]                  out_change_mask,
  output logic                        out_last
);
  import pfcs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_UPD, S_WALK, S_WCHK} state_t;

  state_t                state_r;
  cmd_t                  cmd_r;
  logic [STAMP_BITS-1:0] frame_r;
  logic [IDX_W-1:0]      i_r;
  logic [MAX_FILES-1:0]  open_r, seen_r;

  // per-file memories
  logic [PROG_W-1:0]     prog_mem  [MAX_FILES];
  logic [STAMP_BITS-1:0] prog_stp  [MAX_FILES];
  logic [2:0]            prio_mem  [MAX_FILES];
  logic [STAMP_BITS-1:0] prio_stp  [MAX_FILES];
  logic [7:0]            mode_mem  [MAX_FILES];
  logic [STAMP_BITS-1:0] mode_stp  [MAX_FILES];
  logic [MAX_FILES-1:0]  written_r;

  logic [PROG_W-1:0]     prog_q;
  logic [STAMP_BITS-1:0] pstp_q, rstp_q, mstp_q;
  logic [2:0]            prio_q;
  logic [7:0]            mode_q;
  logic                  wr_q;

  logic [IDX_W-1:0]      rd_a;
  logic                  out_free;
  logic [5:0]            qmask;
  logic                  i_last;

  assign out_free = !out_valid || !out_stall;
  assign rd_a     = (state_r == S_RD) ? cmd_r.idx : i_r;
  assign i_last   = ({1'b0, i_r} + 7'd1) == cmd_r.n;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // registered memory reads
  always_ff @(posedge clk) begin
    prog_q <= prog_mem[rd_a];
    pstp_q <= prog_stp[rd_a];
    prio_q <= prio_mem[rd_a];
    rstp_q <= prio_stp[rd_a];
    mode_q <= mode_mem[rd_a];
    mstp_q <= mode_stp[rd_a];
  end

  // query mask from the registered read (never-written entries read as zero)
  always_comb begin
    logic [STAMP_BITS-1:0] ps, rs, ms;
    ps = wr_q ? pstp_q : '0;
    rs = wr_q ? rstp_q : '0;
    ms = wr_q ? mstp_q : '0;
    qmask = (cmd_r.since == '0) ? (cmd_r.req & MASK_STATIC) : 6'h00;
    if ((cmd_r.req & MASK_PROG) != 6'h00 && ps > cmd_r.since) qmask = qmask | MASK_PROG;
    if ((cmd_r.req & MASK_PRIO) != 6'h00 && rs > cmd_r.since) qmask = qmask | MASK_PRIO;
    if ((cmd_r.req & MASK_MODE) != 6'h00 && ms > cmd_r.since) qmask = qmask | MASK_MODE;
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      frame_r   <= '0;
      open_r    <= '0;
      seen_r    <= '0;
      written_r <= '0;
      out_valid <= 1'b0;
      i_r       <= '0;
      wr_q      <= 1'b0;
    end else begin
      wr_q <= written_r[rd_a];
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            i_r   <= '0;
            unique case (q_cmd.op)
              OP_BEGIN: state_r <= S_UPD;
              OP_PROG, OP_PRIO, OP_OPEN: state_r <= q_cmd.in_range ? S_RD : S_IDLE;
              OP_END:   state_r <= S_WALK;
              OP_QUERY: state_r <= (q_cmd.n == '0) ? S_IDLE : S_WALK;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          if (cmd_r.op == OP_BEGIN) begin
            if (out_free) begin
              if (frame_r != '1) frame_r <= frame_r + 1'b1;
              out_valid        <= 1'b1;
              out_kind         <= 1'b0;
              out_frame_number <= (frame_r != '1) ? frame_r + 1'b1 : frame_r;
              out_out_index    <= '0;
              out_change_mask  <= '0;
              out_last         <= 1'b1;
              state_r          <= S_IDLE;
            end
          end else begin
            written_r[cmd_r.idx] <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_WALK: begin
          if (cmd_r.op == OP_END) begin
            if ({1'b0, i_r} < cmd_r.n) begin
              open_r[i_r] <= seen_r[i_r];
            end else begin
              open_r[i_r] <= 1'b0;
            end
            seen_r[i_r] <= 1'b0;
            i_r <= i_r + 1'b1;
            if (i_r == IDX_W'(MAX_FILES-1)) state_r <= S_IDLE;
          end else begin
            state_r <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_kind         <= 1'b1;
            out_frame_number <= '0;
            out_out_index    <= i_r;
            out_change_mask  <= qmask;
            out_last         <= i_last;
            i_r              <= i_r + 1'b1;
            state_r          <= i_last ? S_IDLE : S_WALK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_UPD && cmd_r.op == OP_OPEN) seen_r[cmd_r.idx] <= 1'b1;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      unique case (cmd_r.op)
        OP_PROG: begin
          if ((wr_q ? prog_q : '0) != cmd_r.prog) begin
            prog_mem[cmd_r.idx] <= cmd_r.prog;
            prog_stp[cmd_r.idx] <= frame_r;
          end else if (!wr_q) begin
            prog_mem[cmd_r.idx] <= '0;
            prog_stp[cmd_r.idx] <= '0;
          end
          if (!wr_q) begin
            prio_mem[cmd_r.idx] <= '0;
            prio_stp[cmd_r.idx] <= '0;
            mode_mem[cmd_r.idx] <= '0;
            mode_stp[cmd_r.idx] <= '0;
          end
        end
        OP_PRIO: begin
          if ((wr_q ? prio_q : 3'd0) != cmd_r.prio) begin
            prio_mem[cmd_r.idx] <= cmd_r.prio;
            prio_stp[cmd_r.idx] <= frame_r;
          end else begin
            prio_mem[cmd_r.idx] <= cmd_r.prio;
            prio_stp[cmd_r.idx] <= wr_q ? rstp_q : '0;
          end
          if (!wr_q) begin
            prog_mem[cmd_r.idx] <= '0;
            prog_stp[cmd_r.idx] <= '0;
            mode_mem[cmd_r.idx] <= '0;
            mode_stp[cmd_r.idx] <= '0;
          end
        end
        OP_OPEN: begin
          if (!open_r[cmd_r.idx] || (wr_q ? mode_q : 8'd0) != cmd_r.mode) begin
            mode_mem[cmd_r.idx] <= cmd_r.mode;
            mode_stp[cmd_r.idx] <= frame_r;
          end else begin
            mode_mem[cmd_r.idx] <= cmd_r.mode;
            mode_stp[cmd_r.idx] <= wr_q ? mstp_q : '0;
          end
          if (!wr_q) begin
            prog_mem[cmd_r.idx] <= '0;
            prog_stp[cmd_r.idx] <= '0;
            prio_mem[cmd_r.idx] <= '0;
            prio_stp[cmd_r.idx] <= '0;
          end
        end
        default: ;
      endcase
    end else if (state_r == S_WALK && cmd_r.op == OP_END) begin
      if ({1'b0, i_r} < cmd_r.n && open_r[i_r] && !seen_r[i_r]) begin
        mode_mem[i_r] <= '0;
        mode_stp[i_r] <= frame_r;
        if (!written_r[i_r]) begin
          prog_mem[i_r] <= '0;
          prog_stp[i_r] <= '0;
          prio_mem[i_r] <= '0;
          prio_stp[i_r] <= '0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_last_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> out_last) else $error("frame report without last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_frame_mono: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r >= $past(frame_r) || $past(!rst_n)) else $error("frame went back");
`endif

endmodule

// ===== hdl/per_file_change_stamp_table_top.sv =====
// channel | signals                         | accepted when
// in      | in_valid, in_stall, in_* fields | in_valid && !in_stall
// out     | out_valid, out_stall, out_*     | out_valid && !out_stall
// cfg     | cfg_we, cfg_wdata               | cfg_we
// updates pass pop, read and compare/write states in the back end; out of range ones only pop
// begin frame goes from pop to the update state and waits there while the output stalls
// query walks each tracked file (walk, check); end snapshot walks all 64 files
// a 4-entry command queue lets the input side run ahead of the back end
// rst_n is synchronous, active low; out_stall reaches in_stall only once the queue fills
module per_file_change_stamp_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [5:0]  in_file_index,
  input  logic [62:0] in_progress_value,
  input  logic [2:0]  in_priority_value,
  input  logic [7:0]  in_mode_value,
  input  logic [31:0] in_since_frame,
  input  logic [5:0]  in_requested_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_frame_number,
  output logic [5:0]  out_out_index,
  output logic [5:0]  out_change_mask,
  output logic        out_last
);
  import pfcs_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  // front: accept and classify
  pfcs_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_op, .in_file_index,
    .in_progress_value, .in_priority_value, .in_mode_value, .in_since_frame,
    .in_requested_mask, .q_valid, .q_cmd, .q_pop
  );

  // back: execute
  pfcs_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_stall, .out_kind,
    .out_frame_number, .out_out_index, .out_change_mask, .out_last
  );

endmodule

// ===== tb/tb_per_file_change_stamp_table_top.sv =====
`timescale 1ns / 1ps

module tb_per_file_change_stamp_table_top;
  import pfcs_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [62:0] prog;
    logic [2:0]  prio;
    logic [7:0]  mode;
    logic [31:0] since;
    logic [5:0]  req;
  } file_cmd_t;

  typedef struct {
    logic        kind;
    logic [31:0] frame;
    logic [5:0]  idx;
    logic [5:0]  mask;
    logic        last;
  } stamp_report_t;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         DRAIN_WAIT  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [5:0]  in_file_index = '0;
  logic [62:0] in_progress_value = '0;
  logic [2:0]  in_priority_value = '0;
  logic [7:0]  in_mode_value = '0;
  logic [31:0] in_since_frame = '0;
  logic [5:0]  in_requested_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [31:0] out_frame_number;
  logic [5:0]  out_out_index;
  logic [5:0]  out_change_mask;
  logic        out_last;

  per_file_change_stamp_table_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_file_index(in_file_index), .in_progress_value(in_progress_value),
    .in_priority_value(in_priority_value), .in_mode_value(in_mode_value),
    .in_since_frame(in_since_frame), .in_requested_mask(in_requested_mask),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_frame_number(out_frame_number), .out_out_index(out_out_index),
    .out_change_mask(out_change_mask), .out_last(out_last)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  file_cmd_t     cmd_backlog[$];
  stamp_report_t pending_reports[$];
  int            mismatches = 0;
  int            fail_count = 0;
  int            cycles = 0;

  // shadow copy of the table state
  logic [6:0]  tracked_cfg = 7'd64;
  logic [31:0] frame_ctr = '0;
  logic [62:0] prog_tbl[MAX_FILES];
  logic [31:0] prog_stamp[MAX_FILES];
  logic [2:0]  prio_tbl[MAX_FILES];
  logic [31:0] prio_stamp[MAX_FILES];
  logic [7:0]  mode_tbl[MAX_FILES];
  logic [31:0] mode_stamp[MAX_FILES];
  logic        is_open[MAX_FILES];
  logic        is_seen[MAX_FILES];

  // knobs set by the stimulus process
  int          gap_max = 4;
  int          stall_pct = 30;
  bit          hold_req = 0;
  int          frames_sent = 0;

  initial begin
    for (int i = 0; i < MAX_FILES; i++) begin
      prog_tbl[i] = '0; prog_stamp[i] = '0; prio_tbl[i] = '0; prio_stamp[i] = '0;
      mode_tbl[i] = '0; mode_stamp[i] = '0; is_open[i] = 0; is_seen[i] = 0;
    end
  end

  // work out the reports one accepted transaction causes
  task automatic apply_file_cmd(input file_cmd_t c);
    int n;
    int fi;
    stamp_report_t r;
    logic [5:0] stat;
    n = (tracked_cfg > MAX_FILES) ? MAX_FILES : int'(tracked_cfg);
    fi = int'(c.idx);
    case (c.op)
      OP_BEGIN: begin
        if (frame_ctr != '1) frame_ctr++;
        r.kind = 1'b0; r.frame = frame_ctr; r.idx = '0; r.mask = '0; r.last = 1'b1;
        pending_reports.insert(pending_reports.size(), r);
      end
      OP_PROG: begin
        if (fi < n && prog_tbl[fi] != c.prog) begin
          prog_tbl[fi] = c.prog; prog_stamp[fi] = frame_ctr;
        end
      end
      OP_PRIO: begin
        if (fi < n && prio_tbl[fi] != c.prio) begin
          prio_tbl[fi] = c.prio; prio_stamp[fi] = frame_ctr;
        end
      end
      OP_OPEN: begin
        if (fi < n) begin
          if (!is_open[fi] || mode_tbl[fi] != c.mode) begin
            mode_tbl[fi] = c.mode; mode_stamp[fi] = frame_ctr;
          end
          is_seen[fi] = 1;
        end
      end
      OP_END: begin
        for (int i = 0; i < MAX_FILES; i++) begin
          if (i < n && is_open[i] && !is_seen[i]) begin
            mode_tbl[i] = '0; mode_stamp[i] = frame_ctr;
          end
          is_open[i] = (i < n) && is_seen[i];
          is_seen[i] = 0;
        end
      end
      OP_QUERY: begin
        stat = (c.since == '0) ? (c.req & MASK_STATIC) : '0;
        for (int i = 0; i < n; i++) begin
          r.kind = 1'b1; r.frame = '0; r.idx = i[5:0]; r.mask = stat;
          if ((c.req & MASK_PROG) != 0 && prog_stamp[i] > c.since) r.mask |= MASK_PROG;
          if ((c.req & MASK_PRIO) != 0 && prio_stamp[i] > c.since) r.mask |= MASK_PRIO;
          if ((c.req & MASK_MODE) != 0 && mode_stamp[i] > c.since) r.mask |= MASK_MODE;
          r.last = (i + 1 == n);
          pending_reports.insert(pending_reports.size(), r);
        end
      end
      default: ;
    endcase
  endtask

  // driver: bursts of transactions with random gaps
  int burst_left = 1;
  int gap_left = 0;
  file_cmd_t cur_cmd;
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) apply_file_cmd(cur_cmd);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cur_cmd = cmd_backlog.pop_front();
        in_valid <= 1'b1;
        in_op <= cur_cmd.op;
        in_file_index <= cur_cmd.idx;
        in_progress_value <= cur_cmd.prog;
        in_priority_value <= cur_cmd.prio;
        in_mode_value <= cur_cmd.mode;
        in_since_frame <= cur_cmd.since;
        in_requested_mask <= cur_cmd.req;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  stamp_report_t exp_r;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_per_file_change_stamp_table_top: errors");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (mismatches < 10) $display("unexpected result: kind %0d idx %0d", out_kind,
                                      out_out_index);
        mismatches++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (out_kind !== exp_r.kind || out_frame_number !== exp_r.frame ||
            out_out_index !== exp_r.idx || out_change_mask !== exp_r.mask ||
            out_last !== exp_r.last) begin
          fail_count++;
          if (mismatches < 10)
            $display("mismatch: exp k%0d f%0d i%0d m%h l%0d got k%0d f%0d i%0d m%h l%0d",
                     exp_r.kind, exp_r.frame, exp_r.idx, exp_r.mask, exp_r.last,
                     out_kind, out_frame_number, out_out_index, out_change_mask,
                     out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [5:0] idx,
                         input logic [62:0] prog, input logic [2:0] prio,
                         input logic [7:0] mode, input logic [31:0] since,
                         input logic [5:0] req);
    file_cmd_t c;
    c.op = op; c.idx = idx; c.prog = prog; c.prio = prio; c.mode = mode;
    c.since = since; c.req = req;
    if (op == OP_BEGIN) frames_sent++;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  function automatic logic [62:0] pick_progress();
    if ($urandom_range(0, 2) == 0) return 63'($urandom_range(0, 3));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] pick_index(input int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom);
    return 6'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [31:0] pick_since();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return 32'($urandom_range(0, frames_sent + 1));
    endcase
  endfunction

  // random mix, mostly well-formed snapshots between frames
  task automatic fill_random(input int count, input int n);
    int k;
    logic [5:0] ix;
    for (int j = 0; j < count; j++) begin
      case ($urandom_range(0, 9))
        0, 1: add_cmd(OP_BEGIN, 6'($urandom), 63'(0), 3'($urandom), 8'($urandom),
                      $urandom, 6'($urandom));
        2, 3: add_cmd(OP_PROG, pick_index(n), pick_progress(), 3'($urandom),
                      8'($urandom), $urandom, 6'($urandom));
        4: add_cmd(OP_PRIO, pick_index(n), pick_progress(), 3'($urandom),
                   8'($urandom), $urandom, 6'($urandom));
        5, 6: begin
          k = $urandom_range(0, 5);
          for (int e = 0; e < k; e++) begin
            ix = pick_index(n);
            add_cmd(OP_OPEN, ix, pick_progress(), 3'($urandom),
                    ($urandom_range(0, 1) != 0) ? mode_tbl[ix] : 8'($urandom),
                    $urandom, 6'($urandom));
          end
          if ($urandom_range(0, 7) != 0)
            add_cmd(OP_END, 6'($urandom), 63'(0), 3'($urandom), 8'($urandom),
                    $urandom, 6'($urandom));
          j += k;
        end
        7, 8: add_cmd(OP_QUERY, 6'($urandom), pick_progress(), 3'($urandom),
                      8'($urandom), pick_since(), 6'($urandom));
        default: add_cmd(($urandom_range(0, 1) != 0) ? OP_UNUSED_A : OP_UNUSED_B,
                         6'($urandom), pick_progress(), 3'($urandom), 8'($urandom),
                         $urandom, 6'($urandom));
      endcase
    end
  endtask

  // wait for the block to go idle, then write the file count
  task automatic settle_and_config(input logic [6:0] value);
    wait (cmd_backlog.size() == 0 && !in_valid && pending_reports.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracked_cfg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  int eff;
  logic [6:0] phase_cfg[5] = '{7'd1, 7'd0, 7'd37, 7'd127, 7'd64};

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settle_and_config(7'd64);

    // directed: updates before any frame, extremes, every op
    add_cmd(OP_PROG, 6'd0, '1, 3'd7, 8'hFF, '1, 6'h3F);
    add_cmd(OP_PRIO, 6'd63, '0, 3'd7, 8'h00, '0, 6'h00);
    add_cmd(OP_QUERY, 6'd0, '0, 3'd0, 8'h00, '0, 6'h3F);
    add_cmd(OP_BEGIN, 6'd0, '0, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_PROG, 6'd0, '1, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_PROG, 6'd63, 63'h2AAA_AAAA_AAAA_AAAA, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_PRIO, 6'd5, '0, 3'd7, 8'h00, '0, 6'h00);
    add_cmd(OP_OPEN, 6'd1, '0, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_OPEN, 6'd2, '0, 3'd0, 8'hFF, '0, 6'h00);
    add_cmd(OP_OPEN, 6'd2, '0, 3'd0, 8'hA5, '0, 6'h00);
    add_cmd(OP_END, 6'd0, '0, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_BEGIN, 6'd0, '0, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_OPEN, 6'd2, '0, 3'd0, 8'hA5, '0, 6'h00);
    add_cmd(OP_END, 6'd0, '0, 3'd0, 8'h00, '0, 6'h00);
    add_cmd(OP_QUERY, 6'd0, '0, 3'd0, 8'h00, 32'd1, 6'h38);
    add_cmd(OP_QUERY, 6'd0, '0, 3'd0, 8'h00, '1, 6'h3F);
    add_cmd(OP_UNUSED_A, '1, '1, '1, '1, '1, '1);
    add_cmd(OP_UNUSED_B, '1, '1, '1, '1, '1, '1);
    add_cmd(OP_QUERY, 6'd0, '0, 3'd0, 8'h00, '0, 6'h07);

    // random phases over several file counts; stall patterns vary per phase
    fill_random(60, 64);
    for (int p = 0; p < 5; p++) begin
      settle_and_config(phase_cfg[p]);
      eff = (phase_cfg[p] > MAX_FILES) ? MAX_FILES : int'(phase_cfg[p]);
      gap_max = (p == 2) ? 0 : $urandom_range(1, 6);
      stall_pct = (p == 3) ? 0 : $urandom_range(10, 60);
      fill_random(60, eff);
      if (p == 4) begin
        @(posedge clk);
        hold_req = 1;
      end
    end

    wait (cmd_backlog.size() == 0 && !in_valid && pending_reports.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_reports.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb_per_file_change_stamp_table_top: clean");
    end else begin
      $display("tb_per_file_change_stamp_table_top: errors");
    end
    $finish;
  end

endmodule

// ===== per_file_change_stamp_table_top.f =====
hdl/pfcs_pkg.sv
hdl/pfcs_front.sv
hdl/pfcs_back.sv
hdl/per_file_change_stamp_table_top.sv
tb/tb_per_file_change_stamp_table_top.sv
